>>> src/rtuq_pkg.sv
package rtuq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int W_OUT_W       = 15;
  localparam int V_OUT_W       = 16;
  localparam int QUEUE_DEPTH   = 2;

  // sign of each off-diagonal difference, set when the difference is below zero
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } sign_t;

  // signed radicand width: 1.0 plus three 16-bit terms
  function automatic int rad_w(input int f);
    return ((f > 17) ? f : 17) + 2;
  endfunction

  // one root bit per stage; radicand scaled up by f-2 bits before the root
  function automatic int sqrt_stages(input int f);
    return (rad_w(f) - 1 + f - 2 + 1) / 2;
  endfunction

endpackage

>>> src/rtuq_front.sv
module rtuq_front #(
  parameter int FRAC_BITS = rtuq_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row0_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row0_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row0_col2,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row1_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row1_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row1_col2,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row2_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row2_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]           row2_col2,
  input  logic                                       queue_full,
  output logic                                       push,
  output logic [3:0][rtuq_pkg::rad_w(FRAC_BITS)-2:0] rad,
  output rtuq_pkg::sign_t                            signs
);
  import rtuq_pkg::*;

  localparam int RW  = rad_w(FRAC_BITS);
  localparam int RPW = RW - 1;
  localparam logic signed [RW-1:0] ONE_V = RW'(64'd1 << FRAC_BITS);

  logic signed [RW-1:0]   xx_e, yy_e, zz_e;
  logic signed [RW-1:0]   rsum [4];
  logic signed [IN_W:0]   dx, dy, dz;
  logic [3:0][RPW-1:0]    rad_nxt, rad_r;
  sign_t                  sign_nxt, sign_r;
  logic                   valid_r, valid_nxt;
  logic                   take, load;

  assign xx_e = RW'(row0_col0);
  assign yy_e = RW'(row1_col1);
  assign zz_e = RW'(row2_col2);

  assign rsum[0] = ONE_V + xx_e + yy_e + zz_e;
  assign rsum[1] = ONE_V + xx_e - yy_e - zz_e;
  assign rsum[2] = ONE_V - xx_e + yy_e - zz_e;
  assign rsum[3] = ONE_V - xx_e - yy_e + zz_e;

  // rounding can push a radicand below zero: clamp
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rad_nxt[i] = rsum[i][RW-1] ? '0 : rsum[i][RPW-1:0];
    end
  end

  assign dx = (IN_W+1)'(row2_col1) - (IN_W+1)'(row1_col2);
  assign dy = (IN_W+1)'(row0_col2) - (IN_W+1)'(row2_col0);
  assign dz = (IN_W+1)'(row1_col0) - (IN_W+1)'(row0_col1);

  // zero difference counts as positive
  assign sign_nxt = '{x_neg: dx[IN_W], y_neg: dy[IN_W], z_neg: dz[IN_W]};

  assign push = valid_r && !queue_full;
  assign busy = valid_r && queue_full;
  assign take = start && !busy;
  assign load = take;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rad_r  <= rad_nxt;
      sign_r <= sign_nxt;
    end
  end

  assign rad   = rad_r;
  assign signs = sign_r;

endmodule

>>> src/rtuq_queue.sv
module rtuq_queue #(
  parameter int DW    = 75,
  parameter int DEPTH = rtuq_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);
  import rtuq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  // the back end takes a request every cycle one is waiting
  assign pop       = (count_r != '0);
  assign pop_valid = pop;
  assign pop_data  = mem_r[rd_ptr_r];
  assign full      = (count_r == CW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/rtuq_sqrt.sv
module rtuq_sqrt #(
  parameter int H = 15
) (
  input  logic           clk,
  input  logic [2*H-1:0] n_in,
  output logic [H-1:0]   root_out,
  output logic [H+1:0]   rem_out
);
  import rtuq_pkg::*;

  localparam int NW = 2 * H;

  logic [NW-1:0] n_r    [H-1];
  logic [H-1:0]  root_r [H];
  logic [H+1:0]  rem_r  [H];

  // digit-by-digit root, one result bit per stage; remainder kept for rounding
  for (genvar k = 0; k < H; k++) begin : g_stage
    logic [NW-1:0] n_prev;
    logic [H-1:0]  root_prev;
    logic [H+1:0]  rem_prev;
    logic [H+3:0]  rem_sh, trial, rem_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign n_prev    = n_in;
      assign root_prev = '0;
      assign rem_prev  = '0;
    end else begin : g_next
      assign n_prev    = n_r[k-1];
      assign root_prev = root_r[k-1];
      assign rem_prev  = rem_r[k-1];
    end

    assign rem_sh  = {rem_prev, n_prev[NW-1-2*k -: 2]};
    assign trial   = {2'b00, root_prev, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      root_r[k] <= {root_prev[H-2:0], ge};
      rem_r[k]  <= ge ? rem_sub[H+1:0] : rem_sh[H+1:0];
    end

    if (k < H - 1) begin : g_carry
      always_ff @(posedge clk) begin
        n_r[k] <= n_prev;
      end
    end
  end

  assign root_out = root_r[H-1];
  assign rem_out  = rem_r[H-1];

endmodule

>>> src/rtuq_back.sv
module rtuq_back #(
  parameter int FRAC_BITS = rtuq_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       req_valid,
  input  logic [3:0][rtuq_pkg::rad_w(FRAC_BITS)-2:0] rad,
  input  rtuq_pkg::sign_t                            signs,
  output logic                                       out_valid,
  output logic [rtuq_pkg::W_OUT_W-1:0]               out_quat_w,
  output logic signed [rtuq_pkg::V_OUT_W-1:0]        out_quat_x,
  output logic signed [rtuq_pkg::V_OUT_W-1:0]        out_quat_y,
  output logic signed [rtuq_pkg::V_OUT_W-1:0]        out_quat_z
);
  import rtuq_pkg::*;

  localparam int RPW = rad_w(FRAC_BITS) - 1;
  localparam int H   = sqrt_stages(FRAC_BITS);
  localparam int NW  = 2 * H;
  localparam int MW  = FRAC_BITS + 1;
  localparam int OW  = (MW > V_OUT_W) ? MW : V_OUT_W;
  localparam logic [H:0] ONE_Q = (H+1)'(64'd1 << FRAC_BITS);

  logic        vld_r  [H];
  sign_t       sign_r [H];
  logic [OW-1:0] ext  [4];
  logic        out_valid_r;
  logic [W_OUT_W-1:0]        w_r;
  logic [V_OUT_W-1:0]        x_r, y_r, z_r;
  logic [V_OUT_W-1:0]        vec_nxt [3];
  logic [OW-1:0]             neg_ext [3];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [NW-1:0] n_in;
    logic [H-1:0]  root;
    logic [H+1:0]  rem;
    logic [H:0]    q;
    logic [MW-1:0] mag;

    assign n_in = NW'({rad[i], {(FRAC_BITS-2){1'b0}}});

    rtuq_sqrt #(.H(H)) u_sqrt (
      .clk     (clk),
      .n_in    (n_in),
      .root_out(root),
      .rem_out (rem)
    );

    // round to nearest: remainder beyond root means the upper neighbour is closer
    assign q   = (H+1)'(root) + (H+1)'(rem > (H+2)'(root));
    assign mag = (q > ONE_Q) ? ONE_Q[MW-1:0] : q[MW-1:0];
    assign ext[i] = OW'(mag);
  end

  always_comb begin
    neg_ext[0] = sign_r[H-1].x_neg ? (OW'(0) - ext[1]) : ext[1];
    neg_ext[1] = sign_r[H-1].y_neg ? (OW'(0) - ext[2]) : ext[2];
    neg_ext[2] = sign_r[H-1].z_neg ? (OW'(0) - ext[3]) : ext[3];
    for (int j = 0; j < 3; j++) begin
      vec_nxt[j] = neg_ext[j][V_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < H; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= req_valid;
      for (int k = 1; k < H; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[H-1];
    end
  end

  always_ff @(posedge clk) begin
    sign_r[0] <= signs;
    for (int k = 1; k < H; k++) begin
      sign_r[k] <= sign_r[k-1];
    end
    w_r <= ext[0][W_OUT_W-1:0];
    x_r <= vec_nxt[0];
    y_r <= vec_nxt[1];
    z_r <= vec_nxt[2];
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = w_r;
  assign out_quat_x = x_r;
  assign out_quat_y = y_r;
  assign out_quat_z = z_r;

endmodule

>>> src/rotation_to_unit_quaternion_core.sv
// Rotation matrix to unit quaternion. Raise start with the nine Q1.14 matrix entries; the
// request is taken on a clock edge where busy is low. Each request gives one result, shown
// for a single cycle with out_valid high, in request order. A new matrix can be given
// every cycle while busy is low: the front stage forms and clamps the four radicands and
// the signs, a two-entry queue hands them to the back end, and four square-root pipelines
// resolving one root bit per stage run in lock step. The back end never stalls, so busy
// stays low in normal use. There is no output back-pressure: results must be taken when
// shown.
module rotation_to_unit_quaternion_core #(
  parameter int FRAC_BITS = rtuq_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row0_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row0_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row0_col2,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row1_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row1_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row1_col2,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row2_col0,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row2_col1,
  input  logic signed [rtuq_pkg::IN_W-1:0]    in_row2_col2,
  output logic                                out_valid,
  output logic [rtuq_pkg::W_OUT_W-1:0]        out_quat_w,
  output logic signed [rtuq_pkg::V_OUT_W-1:0] out_quat_x,
  output logic signed [rtuq_pkg::V_OUT_W-1:0] out_quat_y,
  output logic signed [rtuq_pkg::V_OUT_W-1:0] out_quat_z
);
  import rtuq_pkg::*;

  localparam int RPW = rad_w(FRAC_BITS) - 1;
  localparam int SW  = $bits(sign_t);
  localparam int DW  = 4 * RPW + SW;

  logic                queue_full, push, pop_valid;
  logic [3:0][RPW-1:0] front_rad, back_rad;
  sign_t               front_signs, back_signs;
  logic [DW-1:0]       push_data, pop_data;

  rtuq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .row0_col0 (in_row0_col0),
    .row0_col1 (in_row0_col1),
    .row0_col2 (in_row0_col2),
    .row1_col0 (in_row1_col0),
    .row1_col1 (in_row1_col1),
    .row1_col2 (in_row1_col2),
    .row2_col0 (in_row2_col0),
    .row2_col1 (in_row2_col1),
    .row2_col2 (in_row2_col2),
    .queue_full(queue_full),
    .push      (push),
    .rad       (front_rad),
    .signs     (front_signs)
  );

  assign push_data = {front_rad, front_signs};

  rtuq_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop_valid(pop_valid),
    .pop_data (pop_data)
  );

  assign back_rad   = pop_data[DW-1:SW];
  assign back_signs = pop_data[SW-1:0];

  rtuq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (pop_valid),
    .rad       (back_rad),
    .signs     (back_signs),
    .out_valid (out_valid),
    .out_quat_w(out_quat_w),
    .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z)
  );

endmodule

>>> src/rtuq_checker.sv
module rtuq_checker #(
  parameter int FRAC_BITS = rtuq_pkg::FRAC_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [rtuq_pkg::W_OUT_W-1:0] out_quat_w
);
  import rtuq_pkg::*;

  localparam int LAT = sqrt_stages(FRAC_BITS) + 3;
  localparam logic [W_OUT_W:0] W_MAX = (W_OUT_W+1)'(64'd1 << FRAC_BITS);

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // every accepted request shows its result after the fixed latency
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing for accepted request");

  // no result without a request that many cycles before
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // scalar part saturates at 1.0
  a_w_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (FRAC_BITS > W_OUT_W - 1) || ({1'b0, out_quat_w} <= W_MAX))
    else $error("scalar part above 1.0");

endmodule

bind rotation_to_unit_quaternion_core rtuq_checker #(.FRAC_BITS(FRAC_BITS)) u_rtuq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_quat_w(out_quat_w)
);

>>> test/rotation_to_unit_quaternion_core_tb.sv
`timescale 1ns / 100ps

module rotation_to_unit_quaternion_core_tb;
  import rtuq_pkg::*;

  localparam int     FRAC   = FRAC_BITS_DEF;
  localparam longint ONE    = 64'sd1 << FRAC;
  localparam int     P_ONE  = 16384;
  localparam int     N_ONE  = -16384;
  localparam int     N_ITEMS = 1750;

  typedef logic signed [IN_W-1:0]    entry_t;
  typedef entry_t                    mat_t [9];
  typedef logic signed [V_OUT_W-1:0] vec_t;
  typedef struct packed {
    logic [W_OUT_W-1:0] w;
    vec_t               x;
    vec_t               y;
    vec_t               z;
  } quat_t;

  // Holds the quaternions still owed by the block, oldest first.
  class quat_ledger;
    quat_t       due[$];
    int unsigned faults;

    function longint unsigned root_nearest(longint unsigned n);
      longint unsigned res, probe, rem;
      rem   = n;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= res + probe) begin
          rem = rem - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      // rem is now n - res^2
      if (rem > res) res++;
      return res;
    endfunction

    // half the root of a radicand; negatives clamp to zero, above 1.0 saturates
    function longint half_root(longint r);
      longint unsigned q;
      if (r <= 0) return 0;
      q = root_nearest(longint'(unsigned'(r)) << (FRAC - 2));
      if (q > ONE) q = ONE;
      return longint'(q);
    endfunction

    // a zero difference counts as positive
    function vec_t signed_part(longint mag, longint diff);
      longint v;
      v = (diff < 0) ? -mag : mag;
      return v[V_OUT_W-1:0];
    endfunction

    function quat_t predict(mat_t m);
      longint e[9];
      longint wm;
      quat_t  q;
      foreach (e[i]) e[i] = longint'(m[i]);
      wm  = half_root(ONE + e[0] + e[4] + e[8]);
      q.w = wm[W_OUT_W-1:0];
      q.x = signed_part(half_root(ONE + e[0] - e[4] - e[8]), e[7] - e[5]);
      q.y = signed_part(half_root(ONE - e[0] + e[4] - e[8]), e[2] - e[6]);
      q.z = signed_part(half_root(ONE - e[0] - e[4] + e[8]), e[3] - e[1]);
      return q;
    endfunction

    function void note_matrix(mat_t m);
      due.push_back(predict(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      if (due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                   got.w, got.x, got.y, got.z);
        return;
      end
      want = due.pop_front();
      if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                   want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  entry_t in_row0_col0 = '0, in_row0_col1 = '0, in_row0_col2 = '0;
  entry_t in_row1_col0 = '0, in_row1_col1 = '0, in_row1_col2 = '0;
  entry_t in_row2_col0 = '0, in_row2_col1 = '0, in_row2_col2 = '0;
  logic               out_valid;
  logic [W_OUT_W-1:0] out_quat_w;
  vec_t               out_quat_x, out_quat_y, out_quat_z;

  quat_ledger ledger = new();
  bit         no_idle = 1'b0;

  rotation_to_unit_quaternion_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_row0_col0 (in_row0_col0),
    .in_row0_col1 (in_row0_col1),
    .in_row0_col2 (in_row0_col2),
    .in_row1_col0 (in_row1_col0),
    .in_row1_col1 (in_row1_col1),
    .in_row1_col2 (in_row1_col2),
    .in_row2_col0 (in_row2_col0),
    .in_row2_col1 (in_row2_col1),
    .in_row2_col2 (in_row2_col2),
    .out_valid    (out_valid),
    .out_quat_w   (out_quat_w),
    .out_quat_x   (out_quat_x),
    .out_quat_y   (out_quat_y),
    .out_quat_z   (out_quat_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      ledger.check_quat({out_quat_w, out_quat_x, out_quat_y, out_quat_z});
  end

  function automatic mat_t mk(int a, int b, int c, int d, int e, int f, int g, int h, int i);
    mat_t m;
    m[0] = entry_t'(a); m[1] = entry_t'(b); m[2] = entry_t'(c);
    m[3] = entry_t'(d); m[4] = entry_t'(e); m[5] = entry_t'(f);
    m[6] = entry_t'(g); m[7] = entry_t'(h); m[8] = entry_t'(i);
    return m;
  endfunction

  function automatic int clamp_unit(int k);
    if (k > P_ONE) return P_ONE;
    if (k < N_ONE) return N_ONE;
    return k;
  endfunction

  function automatic entry_t to_fix(real v);
    real s;
    int  k;
    s = v * 16384.0;
    k = (s >= 0.0) ? $rtoi(s + 0.5) : $rtoi(s - 0.5);
    return entry_t'(clamp_unit(k));
  endfunction

  // proper rotation from a random unit quaternion
  function automatic mat_t random_rotation();
    real  qw, qx, qy, qz, n;
    mat_t m;
    qw = real'($urandom_range(0, 2000)) - 1000.0;
    qx = real'($urandom_range(0, 2000)) - 1000.0;
    qy = real'($urandom_range(0, 2000)) - 1000.0;
    qz = real'($urandom_range(0, 2000)) - 1000.0;
    case ($urandom_range(0, 7))
      0: qw = 0.0;
      1: qx = 0.0;
      2: qw = qw / 50.0;          // near a half turn
      3: begin qy = 0.0; qz = 0.0; end
      default: ;
    endcase
    n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (n < 1.0) begin
      qw = 1.0; qx = 0.0; qy = 0.0; qz = 0.0; n = 1.0;
    end
    qw = qw / n; qx = qx / n; qy = qy / n; qz = qz / n;
    m[0] = to_fix(1.0 - 2.0 * (qy * qy + qz * qz));
    m[1] = to_fix(2.0 * (qx * qy - qw * qz));
    m[2] = to_fix(2.0 * (qx * qz + qw * qy));
    m[3] = to_fix(2.0 * (qx * qy + qw * qz));
    m[4] = to_fix(1.0 - 2.0 * (qx * qx + qz * qz));
    m[5] = to_fix(2.0 * (qy * qz - qw * qx));
    m[6] = to_fix(2.0 * (qx * qz - qw * qy));
    m[7] = to_fix(2.0 * (qy * qz + qw * qx));
    m[8] = to_fix(1.0 - 2.0 * (qx * qx + qy * qy));
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int   sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      m = random_rotation();
    end else if (sel < 75) begin
      m = random_rotation();
      foreach (m[i]) m[i] = entry_t'(clamp_unit(int'(m[i]) + int'($urandom_range(0, 64)) - 32));
    end else if (sel < 90) begin
      foreach (m[i]) m[i] = entry_t'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      // raw words, outside the unit range too
      foreach (m[i]) m[i] = entry_t'($urandom());
    end
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_matrix(input mat_t m);
    int gap;
    start        <= 1'b1;
    in_row0_col0 <= m[0]; in_row0_col1 <= m[1]; in_row0_col2 <= m[2];
    in_row1_col0 <= m[3]; in_row1_col1 <= m[4]; in_row1_col2 <= m[5];
    in_row2_col0 <= m[6]; in_row2_col1 <= m[7]; in_row2_col2 <= m[8];
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ledger.note_matrix(m);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start first so the last request is not taken again while draining
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.due.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_matrix(mk(P_ONE, 0, 0, 0, P_ONE, 0, 0, 0, P_ONE));
    // half turns: all off-diagonal differences zero
    send_matrix(mk(P_ONE, 0, 0, 0, N_ONE, 0, 0, 0, N_ONE));
    send_matrix(mk(N_ONE, 0, 0, 0, P_ONE, 0, 0, 0, N_ONE));
    send_matrix(mk(N_ONE, 0, 0, 0, N_ONE, 0, 0, 0, P_ONE));
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(mk(P_ONE, P_ONE, P_ONE, P_ONE, P_ONE, P_ONE, P_ONE, P_ONE, P_ONE));
    send_matrix(mk(N_ONE, N_ONE, N_ONE, N_ONE, N_ONE, N_ONE, N_ONE, N_ONE, N_ONE));
    // radicand for w negative, the other three positive
    send_matrix(mk(N_ONE, 0, 0, 0, N_ONE, 0, 0, 0, N_ONE));
    // quarter turns both ways about each axis
    send_matrix(mk(P_ONE, 0, 0, 0, 0, N_ONE, 0, P_ONE, 0));
    send_matrix(mk(P_ONE, 0, 0, 0, 0, P_ONE, 0, N_ONE, 0));
    send_matrix(mk(0, 0, P_ONE, 0, P_ONE, 0, N_ONE, 0, 0));
    send_matrix(mk(0, 0, N_ONE, 0, P_ONE, 0, P_ONE, 0, 0));
    send_matrix(mk(0, N_ONE, 0, P_ONE, 0, 0, 0, 0, P_ONE));
    send_matrix(mk(0, P_ONE, 0, N_ONE, 0, 0, 0, 0, P_ONE));
    // out of range: saturation and clamping to zero
    send_matrix(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_matrix(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_matrix(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_matrix(mk(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845));
    send_matrix(mk(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846));
    // nearly a half turn with small negative differences, then nearly identity with small positive ones
    send_matrix(mk(16383, 3, -2, 1, -16383, 5, 4, -7, -16383));
    send_matrix(mk(16383, -1, 1, 1, 16383, -1, -1, 1, 16383));
    wait_drained();

    for (int n = 0; n < N_ITEMS; n++) begin
      if (n % 200 == 0) no_idle = 1'b1;
      if (n % 200 == 40) no_idle = 1'b0;
      if (n == N_ITEMS / 2) wait_drained();
      send_matrix(random_matrix());
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (ledger.due.size() != 0)
      $display("%0d results never arrived", ledger.due.size());
    if (ledger.faults == 0 && ledger.due.size() == 0) begin
      $display("rotation_to_unit_quaternion_core verification clean");
    end else begin
      $display("rotation_to_unit_quaternion_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("rotation_to_unit_quaternion_core verification failed");
    $finish;
  end

endmodule
